/* rtl/spg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spg_pkg: shared types and constants for the step pulse generator
// Field widths, command codes, register indexes and the structs that pass
// between the sequencer and the axis state block.
// ----------------------------------------------------------------------------
package spg_pkg;

  localparam int unsigned TIMER_W = 26;
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned DIV_CNT_W = 5;

  localparam logic [TIMER_W-1:0] MICROS_PER_MINUTE = 26'd60000000;

  // input selector codes
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_MOVE = 1'b1;

  // configuration register indexes
  localparam logic REG_STEPS_PER_REV = 1'b0;
  localparam logic REG_INVERT_DIR    = 1'b1;

  localparam logic [FIELD_W-1:0] STEPS_PER_REV_RESET = 16'd200;

  typedef struct packed {
    logic               tick;
    logic               move;
    logic               stop;
    logic               dir;
    logic [FIELD_W-1:0] count;
    logic [TIMER_W-1:0] period;
  } axis_cmd_t;

  typedef struct packed {
    logic [FIELD_W-1:0] steps_remaining;
    logic [FIELD_W-1:0] position;
    logic               busy_res;
    logic               dir_level;
    logic               step_pulse;
  } axis_res_t;

endpackage

/* rtl/stepper_step_pulse_generator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_step_pulse_generator_core: step/direction pulse generator
// Microsecond ticks advance a step timer; move commands set a new period,
// count and direction, the period coming from a shared iterative divider.
// ----------------------------------------------------------------------------
// channel  dir  handshake             payload
// s_*      in   s_tvalid/s_tready     tuser: func; tdata: move_steps, speed_rpm
// m_*      out  m_tvalid/m_tready     tdata: pulse, dir, busy, position, remaining
// cfg_*    in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
// a tick or a zero-speed move loads the output register directly; the next item is taken while
// the result waits in the output register if it is taken in the same cycle
// a move with nonzero speed makes two 26-step passes through the one
// divider (60000000 / steps_per_rev, then / |speed|); the second pass starts
// when the first is done, and the move is committed when the second is done
// reset clears motion state; steps_per_rev returns to 200, invert to 0
// ----------------------------------------------------------------------------
module stepper_step_pulse_generator_core
  import spg_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [31:0]         s_tdata,   // move_steps [15:0], speed_rpm [31:16]
  input  logic                s_tuser,   // func
  output logic                m_tvalid,
  input  logic                m_tready,
  // step_pulse [0], dir_level [1], busy_res [2], position [18:3],
  // steps_remaining [34:19], zero [39:35]
  output logic [39:0]         m_tdata,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [FIELD_W-1:0]  cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV1 = 2'd1;
  localparam logic [1:0] ST_DIV2 = 2'd2;

  logic [1:0]         state, state_next;
  logic [FIELD_W-1:0] steps_per_rev;
  logic               invert_direction;
  logic [FIELD_W-1:0] spr_eff;

  logic               s_accept;
  logic               is_move;
  logic [FIELD_W-1:0] in_steps;
  logic [FIELD_W-1:0] in_speed;
  logic [FIELD_W-1:0] steps_mag;
  logic [FIELD_W-1:0] speed_mag;

  logic [FIELD_W-1:0] count_r;
  logic [FIELD_W-1:0] speed_mag_r;
  logic               speed_neg_r;

  logic               div_start;
  logic [TIMER_W-1:0] div_dividend;
  logic [FIELD_W-1:0] div_divisor;
  logic               div_done;
  logic [TIMER_W-1:0] div_quot;

  logic               commit_move;
  logic [TIMER_W-1:0] period_sel;
  axis_cmd_t          cmd;
  axis_res_t          res;
  logic               out_load;

  assign cfg_ready = 1'b1;
  assign spr_eff   = (steps_per_rev == '0) ? FIELD_W'(1) : steps_per_rev;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_per_rev    <= STEPS_PER_REV_RESET;
      invert_direction <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STEPS_PER_REV: steps_per_rev    <= cfg_data;
        REG_INVERT_DIR:    invert_direction <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_steps  = s_tdata[FIELD_W-1:0];
  assign in_speed  = s_tdata[2*FIELD_W-1:FIELD_W];
  // most negative value keeps its magnitude 32768
  assign steps_mag = in_steps[FIELD_W-1] ? (~in_steps + 1'b1) : in_steps;
  assign speed_mag = in_speed[FIELD_W-1] ? (~in_speed + 1'b1) : in_speed;

  assign s_tready = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign s_accept = s_tvalid && s_tready;
  assign is_move  = (s_tuser == FUNC_MOVE);

  always_ff @(posedge clk) begin
    if (s_accept && is_move) begin
      count_r     <= steps_mag;
      speed_mag_r <= speed_mag;
      speed_neg_r <= in_speed[FIELD_W-1];
    end
  end

  // sequencer around the shared divider
  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = MICROS_PER_MINUTE;
    div_divisor  = spr_eff;
    commit_move  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (s_accept && is_move && in_speed != '0) begin
          div_start  = 1'b1;
          state_next = ST_DIV1;
        end
      end
      ST_DIV1: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = div_quot;
          div_divisor  = speed_mag_r;
          state_next   = ST_DIV2;
        end
      end
      ST_DIV2: begin
        if (div_done) begin
          commit_move = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  spg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign period_sel = (div_quot == '0) ? TIMER_W'(1) : div_quot;

  always_comb begin
    cmd.tick   = s_accept && (s_tuser == FUNC_TICK);
    cmd.stop   = s_accept && is_move && (in_speed == '0);
    cmd.move   = commit_move;
    cmd.dir    = speed_neg_r ^ invert_direction;
    cmd.count  = count_r;
    cmd.period = period_sel;
  end

  spg_axis u_axis (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .spr_eff (spr_eff),
    .res     (res)
  );

  assign out_load = cmd.tick || cmd.stop || cmd.move;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {5'b0, res.steps_remaining, res.position, res.busy_res,
                  res.dir_level, res.step_pulse};
    end
  end

`ifndef SYNTHESIS
  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> state == ST_IDLE)
    else $error("input ready outside idle");

  a_move_starts_div: assert property (@(posedge clk) disable iff (rst)
    (s_accept && is_move && in_speed != '0) |=> state == ST_DIV1)
    else $error("move did not start the divider");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV1 || state == ST_DIV2))
    else $error("divider finished outside a division step");

  a_commit_out_free: assert property (@(posedge clk) disable iff (rst)
    commit_move |-> !m_tvalid)
    else $error("move result would overwrite a pending transaction");

  a_period_nonzero: assert property (@(posedge clk) disable iff (rst)
    commit_move |-> period_sel != '0)
    else $error("zero step period committed");
`endif

endmodule

/* rtl/spg_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spg_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle over the 26-bit dividend.
// A one-cycle done pulse marks a valid quotient.
// ----------------------------------------------------------------------------
module spg_div
  import spg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [TIMER_W-1:0] dividend,
  input  logic [FIELD_W-1:0] divisor,
  output logic               done,
  output logic [TIMER_W-1:0] quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [FIELD_W-1:0]   rem;
  logic [FIELD_W-1:0]   dvs;
  logic [FIELD_W:0]     rem_sh;
  logic [FIELD_W+1:0]   diff;

  // remainder stays below the divisor, so 16 bits hold it
  assign rem_sh = {rem, quotient[TIMER_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(TIMER_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      if (!diff[FIELD_W+1]) begin
        rem      <= diff[FIELD_W-1:0];
        quotient <= {quotient[TIMER_W-2:0], 1'b1};
      end else begin
        rem      <= rem_sh[FIELD_W-1:0];
        quotient <= {quotient[TIMER_W-2:0], 1'b0};
      end
    end
  end

endmodule

/* rtl/spg_axis.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spg_axis: motion state of the step generator
// Holds period, timer, remaining count, direction and position; applies
// ticks, move starts and stops, and presents the result of the update.
// ----------------------------------------------------------------------------
module spg_axis
  import spg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  axis_cmd_t          cmd,
  input  logic [FIELD_W-1:0] spr_eff,
  output axis_res_t          res
);

  logic [TIMER_W-1:0] period_us, period_us_next;
  logic [TIMER_W-1:0] elapsed_us, elapsed_us_next;
  logic [FIELD_W-1:0] remaining, remaining_next;
  logic               continuous, continuous_next;
  logic               direction, direction_next;
  logic [FIELD_W-1:0] step_position, step_position_next;

  logic               active;
  logic               pulse;
  logic [TIMER_W-1:0] elapsed_inc;
  logic [FIELD_W:0]   pos_inc;
  logic [FIELD_W-1:0] pos_stepped;

  assign active      = (remaining != '0) || continuous;
  assign elapsed_inc = elapsed_us + 1'b1;
  assign pos_inc     = {1'b0, step_position} + 1'b1;

  // wrap within one revolution, counting with the direction level
  always_comb begin
    if (direction) begin
      pos_stepped = (pos_inc >= {1'b0, spr_eff}) ? '0 : pos_inc[FIELD_W-1:0];
    end else if (step_position == '0 || step_position >= spr_eff) begin
      pos_stepped = spr_eff - 1'b1;
    end else begin
      pos_stepped = step_position - 1'b1;
    end
  end

  always_comb begin
    period_us_next     = period_us;
    elapsed_us_next    = elapsed_us;
    remaining_next     = remaining;
    continuous_next    = continuous;
    direction_next     = direction;
    step_position_next = step_position;
    pulse              = 1'b0;
    priority if (cmd.move) begin
      period_us_next  = cmd.period;
      direction_next  = cmd.dir;
      continuous_next = (cmd.count == '0);
      remaining_next  = cmd.count;
      elapsed_us_next = '0;
    end else if (cmd.stop) begin
      continuous_next = 1'b0;
      remaining_next  = '0;
    end else if (cmd.tick && active && period_us != '0) begin
      if (elapsed_inc >= period_us) begin
        elapsed_us_next = elapsed_inc - period_us;
        pulse           = 1'b1;
        if (remaining != '0) begin
          remaining_next     = remaining - 1'b1;
          step_position_next = pos_stepped;
        end
      end else begin
        elapsed_us_next = elapsed_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period_us     <= '0;
      elapsed_us    <= '0;
      remaining     <= '0;
      continuous    <= 1'b0;
      direction     <= 1'b0;
      step_position <= '0;
    end else begin
      period_us     <= period_us_next;
      elapsed_us    <= elapsed_us_next;
      remaining     <= remaining_next;
      continuous    <= continuous_next;
      direction     <= direction_next;
      step_position <= step_position_next;
    end
  end

  assign res.step_pulse      = pulse;
  assign res.dir_level       = direction_next;
  assign res.busy_res        = (remaining_next != '0) || continuous_next;
  assign res.position        = step_position_next;
  assign res.steps_remaining = remaining_next;

endmodule
